FILE: src/gmig_pkg.sv
package gmig_pkg;

   // Register map of the control port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_CELLS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_MODE  = 1'd1;

   // Field widths fixed by the cell and index formats.
   localparam int COORD_W = 10;
   localparam int INDEX_W = 20;

   // One grid cell to expand.
   typedef struct packed {
      logic [COORD_W-1:0] cell_x;
      logic [COORD_W-1:0] cell_z;
   } req_payload_type;

   // One emitted vertex index.
   typedef struct packed {
      logic [INDEX_W-1:0] vertex_index;
      logic               is_last;
      logic               out_of_range;
   } rsp_payload_type;

endpackage

FILE: src/gmig_if.sv
// Cell channel: carries one grid cell per transaction.
interface gmig_req_if import gmig_pkg::*;;
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// Index channel: carries one vertex index per transaction.
interface gmig_rsp_if import gmig_pkg::*;;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: src/grid_mesh_index_generator.sv
// Grid mesh index generator. Each transaction on the cell channel names one
// cell (cell_x, cell_z) of a square grid of N by N cells, N being the
// grid_cells register saturated to MAX_CELLS. The block returns that cell's
// vertex indices into the row-major (N+1) by (N+1) vertex array, one per
// transaction on the index channel, with is_last on the final one: six
// indices for two triangles, or six to ten indices of line pairs when
// line_mode is set. A cell outside the grid returns a single index 0 with
// out_of_range and is_last set. Indices leave at one per clock cycle while
// the index channel is not stalled; the single output port sets that rate.
// The next cell is taken while the current one is still being emitted, so
// consecutive cells follow with no gap between their indices. A cell passes
// through the input, emit and output registers. Registers must be written
// through the csr_ port only while the block is idle; the block does not enforce it.
module grid_mesh_index_generator import gmig_pkg::*; #(
   parameter int MAX_CELLS = 1023
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   gmig_req_if.sink               req_chan,
   gmig_rsp_if.source             rsp_chan
);

   localparam logic [16:0] MAX_CELLS_W = 17'(MAX_CELLS);
   localparam int RAD_W  = COORD_W + 1;
   localparam int STEP_W = 4;

   // Offset of an emitted index from the cell's base index.
   localparam logic [1:0] OFF_BASE  = 2'd0;
   localparam logic [1:0] OFF_RIGHT = 2'd1;
   localparam logic [1:0] OFF_DOWN  = 2'd2;
   localparam logic [1:0] OFF_DIAG  = 2'd3;

   localparam logic [STEP_W-1:0] LAST_TRI  = 4'd5;
   localparam logic [STEP_W-1:0] LAST_LINE = 4'd5;

   logic [COORD_W-1:0] grid_cells_ff, grid_cells_in;
   logic               line_mode_ff, line_mode_in;

   logic               a_valid_ff, a_valid_in;
   logic [COORD_W-1:0] a_x_ff, a_x_in;
   logic [COORD_W-1:0] a_z_ff, a_z_in;

   logic               b_valid_ff, b_valid_in;
   logic [INDEX_W-1:0] b_base_ff, b_base_in;
   logic [RAD_W-1:0]   b_rad_ff, b_rad_in;
   logic               b_oor_ff, b_oor_in;
   logic               b_xe_ff, b_xe_in;
   logic               b_line_ff, b_line_in;
   logic [STEP_W-1:0]  b_last_ff, b_last_in;
   logic [STEP_W-1:0]  b_step_ff, b_step_in;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic               cells_sat;
   logic [COORD_W-1:0] n_cells;
   logic [RAD_W-1:0]   a_rad;
   logic [2*RAD_W-2:0] a_prod;
   logic [INDEX_W-1:0] a_base;
   logic               a_in_range;
   logic               a_xe;
   logic               a_ze;
   logic [STEP_W-1:0]  a_last;

   logic               out_take;
   logic               b_fire;
   logic               b_done;
   logic               b_load;
   logic               a_load;
   logic [1:0]         off_sel;
   logic [RAD_W-1:0]   off_val;
   logic [INDEX_W-1:0] emit_index;

   // Register writes from the control port.
   always_comb begin
      grid_cells_in = grid_cells_ff;
      line_mode_in  = line_mode_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_GRID_CELLS: grid_cells_in = csr_wdata;
            CSR_LINE_MODE:  line_mode_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective grid size, clamped to the largest supported grid.
   assign cells_sat = {7'd0, grid_cells_ff} > MAX_CELLS_W;
   assign n_cells   = cells_sat ? MAX_CELLS_W[COORD_W-1:0] : grid_cells_ff;

   // Handshake between the three stages.
   assign out_take = !rsp_valid_ff || rsp_chan.ready;
   assign b_fire   = b_valid_ff && out_take;
   assign b_done   = b_fire && (b_step_ff == b_last_ff);
   assign b_load   = a_valid_ff && (!b_valid_ff || b_done);
   assign req_chan.ready = !a_valid_ff || b_load;
   assign a_load   = req_chan.valid && req_chan.ready;

   // Input stage: base index, edge tests and the number of indices to emit.
   assign a_rad      = {1'b0, n_cells} + RAD_W'(1);
   assign a_prod     = {{RAD_W{1'b0}}, a_z_ff} * {{COORD_W{1'b0}}, a_rad};
   assign a_base     = a_prod[INDEX_W-1:0] + {{(INDEX_W-COORD_W){1'b0}}, a_x_ff};
   assign a_in_range = (a_x_ff < n_cells) && (a_z_ff < n_cells);
   assign a_xe       = a_x_ff == (n_cells - COORD_W'(1));
   assign a_ze       = a_z_ff == (n_cells - COORD_W'(1));

   always_comb begin
      if (!a_in_range) begin
         a_last = '0;
      end else if (line_mode_ff) begin
         a_last = LAST_LINE + (a_xe ? 4'd2 : 4'd0) + (a_ze ? 4'd2 : 4'd0);
      end else begin
         a_last = LAST_TRI;
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      a_x_in     = a_x_ff;
      a_z_in     = a_z_ff;
      if (a_load) begin
         a_valid_in = 1'b1;
         a_x_in     = req_chan.payload.cell_x;
         a_z_in     = req_chan.payload.cell_z;
      end else if (b_load) begin
         a_valid_in = 1'b0;
      end
   end

   // Emit stage: walks the index sequence of the current cell.
   always_comb begin
      b_valid_in = b_valid_ff;
      b_base_in  = b_base_ff;
      b_rad_in   = b_rad_ff;
      b_oor_in   = b_oor_ff;
      b_xe_in    = b_xe_ff;
      b_line_in  = b_line_ff;
      b_last_in  = b_last_ff;
      b_step_in  = b_step_ff;
      if (b_load) begin
         b_valid_in = 1'b1;
         b_base_in  = a_base;
         b_rad_in   = a_rad;
         b_oor_in   = !a_in_range;
         b_xe_in    = a_xe;
         b_line_in  = line_mode_ff;
         b_last_in  = a_last;
         b_step_in  = '0;
      end else if (b_done) begin
         b_valid_in = 1'b0;
      end else if (b_fire) begin
         b_step_in = b_step_ff + STEP_W'(1);
      end
   end

   // Vertex order: triangles (b, b+R, b+R+1), (b, b+R+1, b+1); lines
   // pairs of top, left and diagonal, then right and bottom edges on the
   // grid border.
   always_comb begin
      if (b_line_ff) begin
         case (b_step_ff)
            4'd0:    off_sel = OFF_BASE;
            4'd1:    off_sel = OFF_RIGHT;
            4'd2:    off_sel = OFF_BASE;
            4'd3:    off_sel = OFF_DOWN;
            4'd4:    off_sel = OFF_BASE;
            4'd5:    off_sel = OFF_DIAG;
            4'd6:    off_sel = b_xe_ff ? OFF_RIGHT : OFF_DOWN;
            4'd7:    off_sel = OFF_DIAG;
            4'd8:    off_sel = OFF_DOWN;
            default: off_sel = OFF_DIAG;
         endcase
      end else begin
         case (b_step_ff)
            4'd0:    off_sel = OFF_BASE;
            4'd1:    off_sel = OFF_DOWN;
            4'd2:    off_sel = OFF_DIAG;
            4'd3:    off_sel = OFF_BASE;
            4'd4:    off_sel = OFF_DIAG;
            default: off_sel = OFF_RIGHT;
         endcase
      end
   end

   always_comb begin
      case (off_sel)
         OFF_BASE:  off_val = '0;
         OFF_RIGHT: off_val = RAD_W'(1);
         OFF_DOWN:  off_val = b_rad_ff;
         default:   off_val = b_rad_ff + RAD_W'(1);
      endcase
   end

   assign emit_index = b_base_ff + {{(INDEX_W-RAD_W){1'b0}}, off_val};

   // Output register, refilled from the emit stage when it is empty or the consumer takes its contents.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (b_fire) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.vertex_index  = b_oor_ff ? '0 : emit_index;
         rsp_data_in.is_last       = b_step_ff == b_last_ff;
         rsp_data_in.out_of_range  = b_oor_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cells_ff <= 10'd64;
         line_mode_ff  <= 1'b0;
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         grid_cells_ff <= grid_cells_in;
         line_mode_ff  <= line_mode_in;
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload state.
   always_ff @(posedge clock) begin
      a_x_ff      <= a_x_in;
      a_z_ff      <= a_z_in;
      b_base_ff   <= b_base_in;
      b_rad_ff    <= b_rad_in;
      b_oor_ff    <= b_oor_in;
      b_xe_ff     <= b_xe_in;
      b_line_ff   <= b_line_in;
      b_last_ff   <= b_last_in;
      b_step_ff   <= b_step_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: test/grid_mesh_index_generator_tb.sv
module grid_mesh_index_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gmig_pkg::*;

   // One row of the directed cell table. Rows with n_typed set carry their
   // index sequence written out by hand; the rest go through the predictor.
   typedef struct packed {
      logic [COORD_W-1:0]      grid_n;
      logic                    lines;
      logic [COORD_W-1:0]      x;
      logic [COORD_W-1:0]      z;
      logic [2:0]              n_typed;
      logic                    oor;
      logic [0:5][INDEX_W-1:0] want;
   } cell_row_type;

   localparam int N_DIRECTED = 17;

   localparam cell_row_type DIRECTED_CELLS [N_DIRECTED] = '{
      // Reset grid of 64 cells, triangles: the corner cell and the far corner.
      '{10'd64, 1'b0, 10'd0, 10'd0, 3'd6, 1'b0,
        {20'd0, 20'd65, 20'd66, 20'd0, 20'd66, 20'd1}},
      '{10'd64, 1'b0, 10'd63, 10'd63, 3'd0, 1'b0, '0},
      // Cells just outside the grid and at the top of the field range, then the last column.
      '{10'd64, 1'b0, 10'd64, 10'd0, 3'd1, 1'b1, '0},
      '{10'd64, 1'b0, 10'd0, 10'd64, 3'd1, 1'b1, '0},
      '{10'd64, 1'b0, 10'd1023, 10'd1023, 3'd1, 1'b1, '0},
      '{10'd64, 1'b0, 10'd63, 10'd0, 3'd0, 1'b0, '0},
      // Single cell grid: both extra edge pairs in line mode, a cell outside, and the triangles.
      '{10'd1, 1'b1, 10'd0, 10'd0, 3'd0, 1'b0, '0},
      '{10'd1, 1'b1, 10'd1, 10'd0, 3'd1, 1'b1, '0},
      '{10'd1, 1'b0, 10'd0, 10'd0, 3'd6, 1'b0,
        {20'd0, 20'd2, 20'd3, 20'd0, 20'd3, 20'd1}},
      // Largest grid: the top of the index range.
      '{10'd1023, 1'b0, 10'd1022, 10'd1022, 3'd0, 1'b0, '0},
      '{10'd1023, 1'b0, 10'd1023, 10'd5, 3'd1, 1'b1, '0},
      '{10'd1023, 1'b1, 10'd1022, 10'd1022, 3'd0, 1'b0, '0},
      '{10'd1023, 1'b1, 10'd1022, 10'd0, 3'd0, 1'b0, '0},
      '{10'd1023, 1'b1, 10'd0, 10'd1022, 3'd0, 1'b0, '0},
      '{10'd1023, 1'b1, 10'd682, 10'd341, 3'd0, 1'b0, '0},
      // Empty grid: every cell lies outside.
      '{10'd0, 1'b1, 10'd0, 10'd0, 3'd1, 1'b1, '0},
      '{10'd0, 1'b0, 10'd5, 10'd7, 3'd1, 1'b1, '0}
   };

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   gmig_req_if req_if();
   gmig_rsp_if rsp_if();

   grid_mesh_index_generator dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if)
   );

   // Grid settings as last written, and the vertex indices still owed.
   logic [COORD_W-1:0] cfg_cells;
   logic               cfg_lines;
   rsp_payload_type    expected_indices [$];
   int unsigned        errors = 0;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   logic        rsp_hold = 1'b0;

   always #10 clock = ~clock;

   // Works out the indices the current grid gives for one cell.
   function automatic void expand_cell(input logic [COORD_W-1:0] x,
                                       input logic [COORD_W-1:0] z);
      int unsigned n, r, b;
      int unsigned seq [$];
      n = cfg_cells;
      if (x >= n || z >= n) begin
         expected_indices.push_back('{vertex_index: '0, is_last: 1'b1,
                                      out_of_range: 1'b1});
         return;
      end
      r = n + 1;
      b = z * r + x;
      if (cfg_lines) begin
         seq = '{b, b + 1, b, b + r, b, b + r + 1};
         if (x == n - 1) begin
            seq.push_back(b + 1);
            seq.push_back(b + r + 1);
         end
         if (z == n - 1) begin
            seq.push_back(b + r);
            seq.push_back(b + r + 1);
         end
      end else begin
         seq = '{b, b + r, b + r + 1, b, b + r + 1, b + 1};
      end
      foreach (seq[k]) begin
         expected_indices.push_back('{vertex_index: INDEX_W'(seq[k]),
                                      is_last: (k == seq.size() - 1),
                                      out_of_range: 1'b0});
      end
   endfunction

   // Picks a coordinate, leaning on the last row or column and on cells
   // outside the grid.
   function automatic logic [COORD_W-1:0] pick_coord(input int unsigned n);
      int unsigned roll;
      roll = $urandom_range(99);
      if (n == 0) return COORD_W'($urandom_range(1023));
      if (roll < 10) return COORD_W'($urandom_range(1023, n));
      if (roll < 35) return COORD_W'(n - 1);
      if (roll < 45) return '0;
      return COORD_W'($urandom_range(n - 1));
   endfunction

   // Writes both grid registers back to back; the line mode write carries
   // random upper bits that the block must drop.
   task automatic set_grid(input logic [COORD_W-1:0] cells, input logic lines);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_GRID_CELLS;
      csr_wdata    <= cells;
      @(posedge clock);
      csr_index <= CSR_LINE_MODE;
      csr_wdata <= {(CSR_DATA_W-1)'($urandom), lines};
      @(posedge clock);
      csr_write_en <= 1'b0;
      cfg_cells = cells;
      cfg_lines = lines;
   endtask

   // Offers one cell and returns at the edge where the transaction is taken.
   task automatic send_cell(input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= '{cell_x: x, cell_z: z};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Stops offering cells and waits until every owed index has arrived.
   task automatic finish_transactions();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (expected_indices.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Index channel: checks each taken transaction and drives ready.
   always @(posedge clock) begin : index_monitor
      rsp_payload_type want;
      if (rsp_if.valid && rsp_if.ready) begin
         if (expected_indices.size() == 0) begin
            $error("unexpected vertex_index %0d", rsp_if.payload.vertex_index);
            errors++;
         end else begin
            want = expected_indices.pop_front();
            if (rsp_if.payload.vertex_index !== want.vertex_index) begin
               $error("vertex_index: expected %0d, got %0d",
                      want.vertex_index, rsp_if.payload.vertex_index);
               errors++;
            end
            if (rsp_if.payload.is_last !== want.is_last) begin
               $error("is_last: expected %0b, got %0b",
                      want.is_last, rsp_if.payload.is_last);
               errors++;
            end
            if (rsp_if.payload.out_of_range !== want.out_of_range) begin
               $error("out_of_range: expected %0b, got %0b",
                      want.out_of_range, rsp_if.payload.out_of_range);
               errors++;
            end
         end
      end
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= stall_pct);
      end
   end

   // Stimulus: directed table, then random phases over several grids.
   initial begin : stimulus
      cell_row_type       row;
      logic [COORD_W-1:0] x, z, cells;
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_index      = CSR_GRID_CELLS;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      cfg_cells      = 10'd64;
      cfg_lines      = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows, regrid only when the row asks for another grid.
      for (int i = 0; i < N_DIRECTED; i++) begin
         row = DIRECTED_CELLS[i];
         if (row.grid_n != cfg_cells || row.lines != cfg_lines) begin
            finish_transactions();
            set_grid(row.grid_n, row.lines);
         end
         send_cell(row.x, row.z);
         if (row.n_typed == 0) begin
            expand_cell(row.x, row.z);
         end else begin
            for (int k = 0; k < row.n_typed; k++) begin
               expected_indices.push_back('{vertex_index: row.want[k],
                                            is_last: (k == row.n_typed - 1),
                                            out_of_range: row.oor});
            end
         end
      end

      // Random phases, each with its own grid and idling pattern.
      for (int p = 0; p < 8; p++) begin
         finish_transactions();
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 57; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 57; end
            default: begin send_idle_pct = 20; stall_pct <= 20; end
         endcase
         case (p)
            0, 4: cells = 10'd1023;
            1: cells = 10'd1;
            2: cells = COORD_W'($urandom_range(8, 2));
            5: cells = 10'd0;
            6: cells = COORD_W'($urandom_range(16, 2));
            default: cells = COORD_W'($urandom_range(1023, 1));
         endcase
         set_grid(cells, p[1]);
         // Hold the index channel off for a long stretch so the block backs up.
         if (p == 0) begin
            fork
               begin
                  rsp_hold <= 1'b1;
                  repeat (300) @(posedge clock);
                  rsp_hold <= 1'b0;
               end
            join_none
         end
         repeat (62) begin
            x = pick_coord(cfg_cells);
            z = pick_coord(cfg_cells);
            send_cell(x, z);
            expand_cell(x, z);
         end
      end

      finish_transactions();
      if (errors == 0) begin
         $display("grid_mesh_index_generator: match");
      end else begin
         $display("grid_mesh_index_generator: mismatch");
      end
      $finish;
   end

   // Watchdog for a block that stops answering.
   initial begin : watchdog
      #5_000_000;
      $display("grid_mesh_index_generator: mismatch");
      $finish;
   end

endmodule

FILE: sim.f
src/gmig_pkg.sv
src/gmig_if.sv
src/grid_mesh_index_generator.sv
test/grid_mesh_index_generator_tb.sv
